@@ rtl/ictf_pkg.sv @@
package ictf_pkg;

  // Sample and result widths
  localparam int RAW_W   = 16;
  localparam int BIAS_W  = 20;
  localparam int CORR_W  = 21;
  localparam int GAIN_W  = 16;
  localparam int ALPHA_W = 17;
  localparam int ANGLE_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  // CORDIC datapath
  localparam int TABLE_LEN  = 24;
  localparam int STEP_W     = 5;
  localparam int CX_W       = 34;
  localparam int ZACC_W     = 26;
  localparam int ATAN_W     = 23;
  localparam int ACC_W      = 18;
  localparam int CORDIC_STEPS_DEF = 16;

  // Shared multiplier and blend
  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = 21;
  localparam int PROD_W   = 55;
  localparam int DSTEP_W  = 26;
  localparam int DIFF_W   = 27;
  localparam int SUM_W    = 44;
  localparam int BSUM_W   = 46;
  localparam int BRES_W   = 30;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic signed [ZACC_W-1:0] BASE_POS = 26'sd11796480;
  localparam logic signed [ZACC_W-1:0] BASE_NEG = -26'sd11796480;

  // atan(2^-i) in 1/65536 degree
  localparam logic signed [ATAN_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    23'sd2949120, 23'sd1740967, 23'sd919879, 23'sd466945,
    23'sd234379,  23'sd117304,  23'sd58666,  23'sd29335,
    23'sd14668,   23'sd7334,    23'sd3667,   23'sd1833,
    23'sd917,     23'sd458,     23'sd229,    23'sd115,
    23'sd57,      23'sd29,      23'sd14,     23'sd7,
    23'sd4,       23'sd2,       23'sd1,      23'sd0
  };

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_BIAS_X = 3'd0,
    REG_ACCEL_BIAS_Y = 3'd1,
    REG_ACCEL_BIAS_Z = 3'd2,
    REG_GYRO_BIAS_X  = 3'd3,
    REG_GYRO_BIAS_Y  = 3'd4,
    REG_GYRO_GAIN    = 3'd5,
    REG_BLEND_ALPHA  = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN,
    S_GAIN_WB,
    S_DMUL,
    S_DWB,
    S_CINIT,
    S_CITER,
    S_CDONE,
    S_BMUL1,
    S_BMUL2,
    S_BWB,
    S_OUT
  } state_t;

  // raw*16 - bias, in 1/16 LSB
  function automatic logic signed [CORR_W-1:0] correct(
    input logic [RAW_W-1:0] raw,
    input logic [BIAS_W-1:0] bias
  );
    logic signed [CORR_W-1:0] r_ext;
    logic signed [CORR_W-1:0] b_ext;
    r_ext = {raw[RAW_W-1], raw, 4'b0000};
    b_ext = {bias[BIAS_W-1], bias};
    return r_ext - b_ext;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat_angle(
    input logic signed [BRES_W-1:0] v
  );
    logic signed [BRES_W-1:0] hi;
    logic signed [BRES_W-1:0] lo;
    hi = BRES_W'(24'sh7FFFFF);
    lo = -(BRES_W'(25'sh0800000));
    if (v > hi) return 24'sh7FFFFF;
    if (v < lo) return 24'sh800000;
    return v[ANGLE_W-1:0];
  endfunction

endpackage

@@ rtl/imu_complementary_tilt_filter.sv @@
// Complementary roll/pitch filter for one IMU sample per transaction. Accel
// offsets are removed, atan2(ax,az) and atan2(-ay,az) are found by a vectoring
// CORDIC in degrees, the gyro y/x step rate*dt is subtracted from the stored
// angle and the two are blended with weight blend_alpha (Q1.16, clamped to
// one). Angles are in 1/256 degree, saturated to 24 bits. A new sample is
// accepted only once the previous one has passed the output state. The work is
// done by one CORDIC shift/add unit run once per axis and one shared 34x21
// multiplier that also forms dt*gain, both gyro steps and the blend products.
// An axis whose accel vector is zero skips its CORDIC iterations, and the
// block holds in its output state while the previous result has not been
// taken. in_ready is low while a sample is in work; a finished result sits in
// the output register while the next sample is accepted.
module imu_complementary_tilt_filter #(
  parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [ictf_pkg::RAW_W-1:0]     in_accel_x,
  input  logic signed [ictf_pkg::RAW_W-1:0]     in_accel_y,
  input  logic signed [ictf_pkg::RAW_W-1:0]     in_accel_z,
  input  logic signed [ictf_pkg::RAW_W-1:0]     in_gyro_x,
  input  logic signed [ictf_pkg::RAW_W-1:0]     in_gyro_y,
  input  logic        [ictf_pkg::RAW_W-1:0]     in_elapsed_ms,

  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ictf_pkg::ANGLE_W-1:0]   out_roll_angle,
  output logic signed [ictf_pkg::ANGLE_W-1:0]   out_pitch_angle,

  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ictf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ictf_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ictf_pkg::*;

  localparam int CORDIC_N = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_N - 1);

  // Configuration registers
  logic [BIAS_W-1:0]  accel_bias_x_r, accel_bias_y_r, accel_bias_z_r;
  logic [BIAS_W-1:0]  gyro_bias_x_r, gyro_bias_y_r;
  logic [GAIN_W-1:0]  gyro_gain_r;
  logic [ALPHA_W-1:0] blend_alpha_r;

  // Sample registers
  logic signed [CORR_W-1:0] axc_r, ayc_r, azc_r, gxc_r, gyc_r;
  logic [RAW_W-1:0]         dt_r;
  logic [2*RAW_W-1:0]       dtg_r;

  // Sequencer
  state_t state_r, state_nxt;
  logic   axis_r;
  logic   zero_r;

  // CORDIC unit
  logic signed [CX_W-1:0]   cx_r, cy_r;
  logic signed [ZACC_W-1:0] cz_r, base_r;
  logic [STEP_W-1:0]        step_r;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  // Per-axis results and filter state
  logic signed [DSTEP_W-1:0] d_roll_r, d_pitch_r;
  logic signed [ACC_W-1:0]   acc_roll_r, acc_pitch_r;
  logic signed [ANGLE_W-1:0] roll_store_r, pitch_store_r;
  logic signed [SUM_W-1:0]   sum_r;

  logic out_valid_r;
  logic signed [ANGLE_W-1:0] out_roll_r, out_pitch_r;

  // Combinational helpers
  logic [ALPHA_W-1:0]        alpha_eff, alpha_inv;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ACC_W-1:0]   acc_sel;
  logic signed [CORR_W-1:0]  gyro_sel;
  logic signed [CORR_W:0]    cin_y, cin_x, neg_y, neg_x, ya, xa;
  logic                      cin_zero;
  logic signed [ZACC_W-1:0]  base_sel;
  logic signed [CX_W-1:0]    cx_sh, cy_sh;
  logic signed [ZACC_W-1:0]  atan_ext;
  logic signed [ZACC_W-1:0]  zround;
  logic signed [PROD_W-1:0]  dround;
  logic signed [BSUM_W-1:0]  bsum;
  logic                      out_free;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_free = !out_valid_r || out_ready;

  // Blend weights, alpha clamped to one
  assign alpha_eff = (blend_alpha_r > ALPHA_ONE) ? ALPHA_ONE : blend_alpha_r;
  assign alpha_inv = ALPHA_ONE - alpha_eff;

  // Select the current axis
  always_comb begin
    if (axis_r) begin
      diff     = DIFF_W'(pitch_store_r) - DIFF_W'(d_pitch_r);
      acc_sel  = acc_pitch_r;
      gyro_sel = gxc_r;
      cin_y    = -{ayc_r[CORR_W-1], ayc_r};
    end else begin
      diff     = DIFF_W'(roll_store_r) - DIFF_W'(d_roll_r);
      acc_sel  = acc_roll_r;
      gyro_sel = gyc_r;
      cin_y    = {axc_r[CORR_W-1], axc_r};
    end
    cin_x = {azc_r[CORR_W-1], azc_r};
  end

  // Fold a negative x into the right half plane
  always_comb begin
    neg_y    = -cin_y;
    neg_x    = -cin_x;
    cin_zero = (cin_x == '0) && (cin_y == '0);
    if (cin_x < 0) begin
      xa       = neg_x;
      ya       = neg_y;
      base_sel = (cin_y >= 0) ? BASE_POS : BASE_NEG;
    end else begin
      xa       = cin_x;
      ya       = cin_y;
      base_sel = '0;
    end
  end

  // CORDIC shift terms and rounding
  assign cx_sh    = cx_r >>> step_r;
  assign cy_sh    = cy_r >>> step_r;
  assign atan_ext = ZACC_W'(ATAN_TAB[step_r]);
  assign zround   = base_r + cz_r + ZACC_W'(128);
  assign dround   = prod_r + PROD_W'(64'sd134217728);
  assign bsum     = BSUM_W'(sum_r) + BSUM_W'($signed(prod_r[SUM_W:0])) + BSUM_W'(32768);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_GAIN;
      S_GAIN:    state_nxt = S_GAIN_WB;
      S_GAIN_WB: state_nxt = S_DMUL;
      S_DMUL:    state_nxt = S_DWB;
      S_DWB:     state_nxt = axis_r ? S_CINIT : S_DMUL;
      S_CINIT:   state_nxt = cin_zero ? S_CDONE : S_CITER;
      S_CITER:   if (step_r == STEP_LAST) state_nxt = S_CDONE;
      S_CDONE:   state_nxt = axis_r ? S_BMUL1 : S_CINIT;
      S_BMUL1:   state_nxt = S_BMUL2;
      S_BMUL2:   state_nxt = S_BWB;
      S_BWB:     state_nxt = axis_r ? S_OUT : S_BMUL1;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Handshake and multiplier operand selection
  always_comb begin
    in_ready = (state_r == S_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      S_GAIN: begin
        mul_a = MUL_A_W'({1'b0, dt_r});
        mul_b = MUL_B_W'({1'b0, gyro_gain_r});
      end
      S_DMUL: begin
        mul_a = MUL_A_W'({1'b0, dtg_r});
        mul_b = gyro_sel;
      end
      S_BMUL1: begin
        mul_a = MUL_A_W'(diff);
        mul_b = MUL_B_W'({1'b0, alpha_eff});
      end
      S_BMUL2: begin
        mul_a = MUL_A_W'(acc_sel);
        mul_b = MUL_B_W'({1'b0, alpha_inv});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      axis_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      roll_store_r  <= '0;
      pitch_store_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) begin
        axis_r <= 1'b0;
      end else if (state_r == S_DWB || state_r == S_CDONE || state_r == S_BWB) begin
        axis_r <= ~axis_r;
      end
      if (state_r == S_BWB) begin
        if (axis_r) pitch_store_r <= sat_angle(bsum[BSUM_W-1:16]);
        else        roll_store_r  <= sat_angle(bsum[BSUM_W-1:16]);
      end
      // Hold the result until taken, then load the next one
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_bias_x_r <= 20'sd14260;
      accel_bias_y_r <= 20'sd3180;
      accel_bias_z_r <= 20'sd7534;
      gyro_bias_x_r  <= -20'sd11168;
      gyro_bias_y_r  <= 20'sd705;
      gyro_gain_r    <= 16'd32786;
      blend_alpha_r  <= 17'd64225;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACCEL_BIAS_X: accel_bias_x_r <= cfg_data;
        REG_ACCEL_BIAS_Y: accel_bias_y_r <= cfg_data;
        REG_ACCEL_BIAS_Z: accel_bias_z_r <= cfg_data;
        REG_GYRO_BIAS_X:  gyro_bias_x_r  <= cfg_data;
        REG_GYRO_BIAS_Y:  gyro_bias_y_r  <= cfg_data;
        REG_GYRO_GAIN:    gyro_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_BLEND_ALPHA:  blend_alpha_r  <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          axc_r <= correct(in_accel_x, accel_bias_x_r);
          ayc_r <= correct(in_accel_y, accel_bias_y_r);
          azc_r <= correct(in_accel_z, accel_bias_z_r);
          gxc_r <= correct(in_gyro_x, gyro_bias_x_r);
          gyc_r <= correct(in_gyro_y, gyro_bias_y_r);
          dt_r  <= in_elapsed_ms;
        end
      end
      S_GAIN_WB: dtg_r <= prod_r[2*RAW_W-1:0];
      S_DWB: begin
        if (axis_r) d_pitch_r <= dround[DSTEP_W+27:28];
        else        d_roll_r  <= dround[DSTEP_W+27:28];
      end
      S_CINIT: begin
        cx_r   <= {{(CX_W-CORR_W-9){xa[CORR_W]}}, xa, 8'b0};
        cy_r   <= {{(CX_W-CORR_W-9){ya[CORR_W]}}, ya, 8'b0};
        cz_r   <= '0;
        base_r <= base_sel;
        step_r <= '0;
        zero_r <= cin_zero;
      end
      // One rotation toward the x axis per cycle
      S_CITER: begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + cy_sh;
          cy_r <= cy_r - cx_sh;
          cz_r <= cz_r + atan_ext;
        end else begin
          cx_r <= cx_r - cy_sh;
          cy_r <= cy_r + cx_sh;
          cz_r <= cz_r - atan_ext;
        end
        step_r <= step_r + STEP_W'(1);
      end
      S_CDONE: begin
        if (axis_r) acc_pitch_r <= zero_r ? '0 : zround[ZACC_W-1:8];
        else        acc_roll_r  <= zero_r ? '0 : zround[ZACC_W-1:8];
      end
      S_BMUL2: sum_r <= prod_r[SUM_W-1:0];
      S_OUT: begin
        if (out_free) begin
          out_roll_r  <= roll_store_r;
          out_pitch_r <= pitch_store_r;
        end
      end
      default: ;
    endcase
  end

  // A sample accepted starts the gain multiply
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_GAIN))
    else $error("accepted sample did not start the sequence");

  // A new result appears only from the output state
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output state");

  // CORDIC step counter stays inside the table
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CITER) |-> (step_r <= STEP_LAST))
    else $error("CORDIC step beyond last iteration");

  // Pitch blend is followed by the output state
  a_blend_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BWB && axis_r) |=> (state_r == S_OUT))
    else $error("sequence skipped the output state");

  // No new sample while one is in work
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("ready raised while busy");

endmodule
